FILE: rtl/i2cwag_pkg.sv
// Shared types and constants for the im2col window address generator.
`default_nettype none

package i2cwag_pkg;

  // Field widths
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int KER_W    = 4;
  localparam int STEP_W   = 4;
  localparam int MARGIN_W = 3;
  localparam int INDEX_W  = 24;
  localparam int TAP_W    = 6;
  localparam int TOTAL_W  = 7;
  localparam int TAP_LIMIT = 64;

  // Configuration register indexes
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_WINDOW_ROWS  = 3'd2;
  localparam logic [2:0] REG_WINDOW_COLS  = 3'd3;
  localparam logic [2:0] REG_STEP_ROWS    = 3'd4;
  localparam logic [2:0] REG_STEP_COLS    = 3'd5;
  localparam logic [2:0] REG_MARGIN_TOP   = 3'd6;
  localparam logic [2:0] REG_MARGIN_LEFT  = 3'd7;

  // One tap issued by the sequencer
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [KER_W-1:0]   ky;
    logic [KER_W-1:0]   kx;
    logic [TAP_W-1:0]   n;
    logic               last;
  } tap_t;

  // Image geometry seen by the address pipeline (dimensions already limited)
  typedef struct packed {
    logic [DIM_W-1:0]    h;
    logic [DIM_W-1:0]    w;
    logic [STEP_W-1:0]   step_rows;
    logic [STEP_W-1:0]   step_cols;
    logic [MARGIN_W-1:0] margin_top;
    logic [MARGIN_W-1:0] margin_left;
  } geom_t;

endpackage

`default_nettype wire

FILE: rtl/im2col_window_address_generator_unit.sv
// Top level of the im2col window address generator.
`default_nettype none

// For each output pixel (out_row, out_col) taken on the slave stream, the unit
// emits one transaction per window tap, at most 64, in row-major order: the source pixel
// index row*width+column (zero for padding taps), an inside flag on tuser,
// the tap number, and tlast on the final tap. The tap sequencer issues one tap
// per cycle while the pipeline accepts taps; the next pixel is taken in the cycle
// after the last tap of the current one has been issued. Each tap is registered
// in the sequencer and then flows through a four-stage pipeline that stalls as a
// whole on m_axis_tready. A pixel whose window is empty is taken and gives no
// result. Configuration is written through cfg_wr_en/cfg_addr/cfg_wr_data
// while idle.

module im2col_window_address_generator_unit
  import i2cwag_pkg::*;
#(
  parameter int MAX_DIM    = 4096,
  parameter int MAX_KERNEL = 8,
  parameter int DILATION_Y = 1,
  parameter int DILATION_X = 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [12:0] cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // out_row[11:0], out_col[23:12]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // pixel_index[23:0], tap_number[29:24], zero
  output logic             m_axis_tuser,   // inside_res[0]
  output logic             m_axis_tlast
);

  localparam int DIM_CAP = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam int KER_CAP = (MAX_KERNEL > 15) ? 15 : MAX_KERNEL;

  logic [DIM_W-1:0]    image_height;
  logic [DIM_W-1:0]    image_width;
  logic [KER_W-1:0]    window_rows;
  logic [KER_W-1:0]    window_cols;
  logic [STEP_W-1:0]   step_rows;
  logic [STEP_W-1:0]   step_cols;
  logic [MARGIN_W-1:0] margin_top;
  logic [MARGIN_W-1:0] margin_left;

  logic [KER_W-1:0]    kr;
  logic [KER_W-1:0]    kc;
  logic [2*KER_W-1:0]  taps;
  logic [TOTAL_W-1:0]  total;
  geom_t               geom;

  logic                tap_valid;
  logic                tap_ready;
  tap_t                tap;
  logic [INDEX_W-1:0]  pixel_index;
  logic [TAP_W-1:0]    tap_number;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= DIM_W'(224);
      image_width  <= DIM_W'(224);
      window_rows  <= KER_W'(3);
      window_cols  <= KER_W'(3);
      step_rows    <= STEP_W'(1);
      step_cols    <= STEP_W'(1);
      margin_top   <= MARGIN_W'(1);
      margin_left  <= MARGIN_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_IMAGE_HEIGHT: image_height <= cfg_wr_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_wr_data;
        REG_WINDOW_ROWS:  window_rows  <= cfg_wr_data[KER_W-1:0];
        REG_WINDOW_COLS:  window_cols  <= cfg_wr_data[KER_W-1:0];
        REG_STEP_ROWS:    step_rows    <= cfg_wr_data[STEP_W-1:0];
        REG_STEP_COLS:    step_cols    <= cfg_wr_data[STEP_W-1:0];
        REG_MARGIN_TOP:   margin_top   <= cfg_wr_data[MARGIN_W-1:0];
        REG_MARGIN_LEFT:  margin_left  <= cfg_wr_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Limit window and image sizes; cap tap count
  always_comb begin
    kr    = (window_rows > KER_W'(KER_CAP)) ? KER_W'(KER_CAP) : window_rows;
    kc    = (window_cols > KER_W'(KER_CAP)) ? KER_W'(KER_CAP) : window_cols;
    taps  = (2*KER_W)'(kr) * (2*KER_W)'(kc);
    total = (taps > (2*KER_W)'(TAP_LIMIT)) ? TOTAL_W'(TAP_LIMIT) : taps[TOTAL_W-1:0];
    geom.h = (image_height > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : image_height;
    geom.w = (image_width > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : image_width;
    geom.step_rows   = step_rows;
    geom.step_cols   = step_cols;
    geom.margin_top  = margin_top;
    geom.margin_left = margin_left;
  end

  i2cwag_tap_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_row    (s_axis_tdata[11:0]),
    .in_col    (s_axis_tdata[23:12]),
    .kc        (kc),
    .total     (total),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .tap       (tap)
  );

  i2cwag_addr_pipe #(
    .DILATION_Y (DILATION_Y),
    .DILATION_X (DILATION_X)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .tap_valid  (tap_valid),
    .tap_ready  (tap_ready),
    .tap        (tap),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_index  (pixel_index),
    .out_inside (m_axis_tuser),
    .out_tap    (tap_number),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, tap_number, pixel_index};

endmodule

`default_nettype wire

FILE: rtl/i2cwag_tap_seq.sv
// Tap sequencer: walks the window of one output pixel, one tap per cycle while tap_ready is high.
`default_nettype none

module i2cwag_tap_seq
  import i2cwag_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [COORD_W-1:0] in_row,
  input  wire logic [COORD_W-1:0] in_col,
  input  wire logic [KER_W-1:0]   kc,
  input  wire logic [TOTAL_W-1:0] total,
  output logic                    tap_valid,
  input  wire logic               tap_ready,
  output tap_t                    tap
);

  logic               busy;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [KER_W-1:0]   ky;
  logic [KER_W-1:0]   kx;
  logic [TAP_W-1:0]   n;
  logic               last;

  assign in_ready  = !busy;
  assign tap_valid = busy;
  assign last      = ((TOTAL_W'(n) + TOTAL_W'(1)) == total);

  always_comb begin
    tap.row  = row;
    tap.col  = col;
    tap.ky   = ky;
    tap.kx   = kx;
    tap.n    = n;
    tap.last = last;
  end

  // Control: busy while taps remain for the current pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy && in_valid) begin
      busy <= (total != '0);
    end else if (busy && tap_ready && last) begin
      busy <= 1'b0;
    end
  end

  // Window counters, row-major
  always_ff @(posedge clk) begin
    if (!busy && in_valid) begin
      row <= in_row;
      col <= in_col;
      ky  <= '0;
      kx  <= '0;
      n   <= '0;
    end else if (busy && tap_ready && !last) begin
      n <= n + TAP_W'(1);
      if (kx == kc - KER_W'(1)) begin
        kx <= '0;
        ky <= ky + KER_W'(1);
      end else begin
        kx <= kx + KER_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/i2cwag_addr_pipe.sv
// Four-stage address pipeline: scale, offset, bounds and multiply, final add.
`default_nettype none

module i2cwag_addr_pipe
  import i2cwag_pkg::*;
#(
  parameter int DILATION_Y = 1,
  parameter int DILATION_X = 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire geom_t              geom,
  input  wire logic               tap_valid,
  output logic                    tap_ready,
  input  wire tap_t               tap,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [INDEX_W-1:0]      out_index,
  output logic                    out_inside,
  output logic [TAP_W-1:0]        out_tap,
  output logic                    out_last
);

  localparam int SCALE_W = COORD_W + STEP_W;
  localparam int KOFF_W  = 8;
  localparam int SY_W    = SCALE_W + 2;
  localparam int MUL_W   = 2 * DIM_W;

  logic advance;

  // Stage 1 registers
  logic               v1;
  logic [SCALE_W-1:0] ry1;
  logic [SCALE_W-1:0] cx1;
  logic [KOFF_W-1:0]  oy1;
  logic [KOFF_W-1:0]  ox1;
  logic [TAP_W-1:0]   n1;
  logic               l1;

  // Stage 2 registers
  logic               v2;
  logic [SY_W-1:0]    sy2;
  logic [SY_W-1:0]    sx2;
  logic [TAP_W-1:0]   n2;
  logic               l2;

  // Stage 3 registers
  logic               v3;
  logic               in3;
  logic [MUL_W-1:0]   mul3;
  logic [DIM_W-1:0]   sx3;
  logic [TAP_W-1:0]   n3;
  logic               l3;

  logic               inside2;

  // Whole pipe moves when the output slot is free or being taken
  assign advance   = !out_valid || out_ready;
  assign tap_ready = advance;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= tap_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Stage 1: coordinate times stride, tap offset times dilation
  always_ff @(posedge clk) begin
    if (advance) begin
      ry1 <= SCALE_W'(tap.row) * SCALE_W'(geom.step_rows);
      cx1 <= SCALE_W'(tap.col) * SCALE_W'(geom.step_cols);
      oy1 <= KOFF_W'(tap.ky) * KOFF_W'(DILATION_Y);
      ox1 <= KOFF_W'(tap.kx) * KOFF_W'(DILATION_X);
      n1  <= tap.n;
      l1  <= tap.last;
    end
  end

  // Stage 2: signed source position
  always_ff @(posedge clk) begin
    if (advance) begin
      sy2 <= SY_W'(ry1) + SY_W'(oy1) - SY_W'(geom.margin_top);
      sx2 <= SY_W'(cx1) + SY_W'(ox1) - SY_W'(geom.margin_left);
      n2  <= n1;
      l2  <= l1;
    end
  end

  // Stage 3: bounds check and row base
  assign inside2 = !sy2[SY_W-1] && (sy2[SY_W-2:0] < (SY_W-1)'(geom.h)) &&
                   !sx2[SY_W-1] && (sx2[SY_W-2:0] < (SY_W-1)'(geom.w));

  always_ff @(posedge clk) begin
    if (advance) begin
      in3  <= inside2;
      mul3 <= MUL_W'(sy2[DIM_W-1:0]) * MUL_W'(geom.w);
      sx3  <= sx2[DIM_W-1:0];
      n3   <= n2;
      l3   <= l2;
    end
  end

  // Stage 4: output register, zero index for padding taps
  always_ff @(posedge clk) begin
    if (advance) begin
      out_index  <= in3 ? INDEX_W'(mul3 + MUL_W'(sx3)) : '0;
      out_inside <= in3;
      out_tap    <= n3;
      out_last   <= l3;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/i2cwag_checker.sv
// Port-level checks for the im2col window address generator, bound to the top.
`default_nettype none

module i2cwag_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // Padding taps carry a zero index
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:0] == 24'd0)
    else $error("padding tap with nonzero index");

  // The 64th tap always closes the window
  a_tap_cap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[29:24] == 6'd63 |-> m_axis_tlast)
    else $error("tap 63 without tlast");

  // Spare tdata bits stay zero
  a_pad_bits: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:30] == 2'b00)
    else $error("tdata pad bits set");

endmodule

bind im2col_window_address_generator_unit i2cwag_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
